### rtl/dfsam_pkg.sv
// ============================================================================
// dfsam_pkg: shared types and constants for the depth-first walk block
// Holds field widths, operation codes and the controller/datapath interface.
// ============================================================================
package dfsam_pkg;

    // Fixed widths of the stream fields.
    localparam int OPCODE_W     = 2;
    localparam int NODE_FIELD_W = 4;
    localparam int S_TDATA_W    = 8;
    localparam int M_TDATA_W    = 8;

    // Operation codes carried in s_tuser.
    localparam logic [OPCODE_W-1:0] OP_ADD_EDGE = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_RUN      = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_CLEAR    = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic add_read;     // latch edge, read its source row
        logic add_write;    // write the row back with the edge set
        logic clear_graph;  // drop every adjacency row
        logic run_start;    // begin a walk at the start node
        logic push;         // descend into the lowest open successor
        logic pop;          // leave the current node, fetch its parent
        logic reload;       // read the parent's adjacency row
        logic finish;       // release the final node with its last flag
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic add_ok;       // edge endpoints are in range
        logic start_ok;     // start node is in range
        logic has_open;     // current row has an unvisited successor
        logic last_level;   // only one node left on the stack
        logic out_free;     // output register can take a beat now
    } stat_t;

endpackage

### rtl/dfsam_ram.sv
// ============================================================================
// dfsam_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered and holds
// its value while no read is issued.
// ============================================================================
module dfsam_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/dfsam_ctrl.sv
// ============================================================================
// dfsam_ctrl: controller for the depth-first walk
// Decodes input beats and steps the walk through descend, backtrack and
// finish, issuing one command set per cycle to the datapath.
// ============================================================================
module dfsam_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [dfsam_pkg::OPCODE_W-1:0] opcode,
    input  dfsam_pkg::stat_t              stat,
    output dfsam_pkg::cmd_t               cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_ADD    = 2'd1;
    localparam logic [1:0] ST_WALK   = 2'd2;
    localparam logic [1:0] ST_RELOAD = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Next state and command decode.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    case (opcode)
                        dfsam_pkg::OP_ADD_EDGE: begin
                            if (stat.add_ok) begin
                                cmd.add_read = 1'b1;
                                state_next   = ST_ADD;
                            end
                        end
                        dfsam_pkg::OP_RUN: begin
                            if (stat.start_ok) begin
                                cmd.run_start = 1'b1;
                                state_next    = ST_WALK;
                            end
                        end
                        dfsam_pkg::OP_CLEAR: begin
                            cmd.clear_graph = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_ADD: begin
                cmd.add_write = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_WALK: begin
                if (stat.has_open) begin
                    // Descending needs room to release the previous node.
                    if (stat.out_free) begin
                        cmd.push = 1'b1;
                    end
                end else if (stat.last_level) begin
                    if (stat.out_free) begin
                        cmd.finish = 1'b1;
                        state_next = ST_IDLE;
                    end
                end else begin
                    cmd.pop    = 1'b1;
                    state_next = ST_RELOAD;
                end
            end
            ST_RELOAD: begin
                cmd.reload = 1'b1;
                state_next = ST_WALK;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/dfsam_dpath.sv
// ============================================================================
// dfsam_dpath: datapath for the depth-first walk
// Holds the adjacency memory with per-row valid bits, the visited marks,
// the node stack, the pending node and the output register.
// ============================================================================
module dfsam_dpath #(
    parameter int NODES = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [dfsam_pkg::NODE_FIELD_W-1:0] from_node,
    input  logic [dfsam_pkg::NODE_FIELD_W-1:0] to_node,
    input  dfsam_pkg::cmd_t                    cmd,
    output dfsam_pkg::stat_t                   stat,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [dfsam_pkg::NODE_FIELD_W-1:0] m_node,
    output logic                               m_tlast
);

    localparam int IDX_W = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int DEP_W = $clog2(NODES + 1);
    localparam int FW    = dfsam_pkg::NODE_FIELD_W;

    // Field conversion between the 4-bit stream fields and node indices.
    logic [IDX_W+FW-1:0] from_ext;
    logic [IDX_W+FW-1:0] to_ext;
    logic [IDX_W-1:0]    from_idx;
    logic [IDX_W-1:0]    to_idx;

    assign from_ext = {{IDX_W{1'b0}}, from_node};
    assign to_ext   = {{IDX_W{1'b0}}, to_node};
    assign from_idx = from_ext[IDX_W-1:0];
    assign to_idx   = to_ext[IDX_W-1:0];

    // Registers.
    logic [IDX_W-1:0] edge_from_reg, edge_from_next;
    logic [IDX_W-1:0] edge_to_reg,   edge_to_next;
    logic [NODES-1:0] row_valid_reg, row_valid_next;
    logic             rd_valid_reg,  rd_valid_next;
    logic [NODES-1:0] visited_reg,   visited_next;
    logic [DEP_W-1:0] depth_reg,     depth_next;
    logic [IDX_W-1:0] pend_reg,      pend_next;
    logic             out_valid_reg, out_valid_next;
    logic [IDX_W-1:0] out_node_reg,  out_node_next;
    logic             out_last_reg,  out_last_next;

    // Memory ports.
    logic             adj_re;
    logic [IDX_W-1:0] adj_raddr;
    logic [NODES-1:0] adj_rdata;
    logic             adj_we;
    logic [NODES-1:0] adj_wdata;
    logic             stk_we;
    logic [IDX_W-1:0] stk_waddr;
    logic [IDX_W-1:0] stk_wdata;
    logic [IDX_W-1:0] stk_raddr;
    logic [IDX_W-1:0] stk_rdata;
    logic [DEP_W-1:0] depth_less2;

    // Row seen at the memory output; an unwritten row reads as empty.
    logic [NODES-1:0] row;
    logic [NODES-1:0] open_set;
    logic [NODES-1:0] to_bit;
    logic [IDX_W-1:0] next_idx;
    logic [IDX_W+FW-1:0] out_ext;

    assign row      = rd_valid_reg ? adj_rdata : '0;
    assign open_set = row & ~visited_reg;
    assign to_bit   = {{(NODES-1){1'b0}}, 1'b1} << edge_to_reg;

    // Lowest-numbered open successor.
    always_comb begin
        next_idx = '0;
        for (int i = NODES - 1; i >= 0; i--) begin
            if (open_set[i]) begin
                next_idx = IDX_W'(i);
            end
        end
    end

    // Status toward the controller.
    assign stat.add_ok     = (32'(from_node) < 32'(NODES)) && (32'(to_node) < 32'(NODES));
    assign stat.start_ok   = 32'(from_node) < 32'(NODES);
    assign stat.has_open   = |open_set;
    assign stat.last_level = depth_reg == DEP_W'(1);
    assign stat.out_free   = !out_valid_reg || m_tready;

    // Adjacency memory addressing.
    always_comb begin
        adj_re    = cmd.add_read || cmd.run_start || cmd.push || cmd.reload;
        adj_raddr = from_idx;
        if (cmd.push) begin
            adj_raddr = next_idx;
        end else if (cmd.reload) begin
            adj_raddr = stk_rdata;
        end
    end

    assign adj_we    = cmd.add_write;
    assign adj_wdata = row | to_bit;

    // Stack addressing: push writes at the current depth, pop reads the parent.
    assign depth_less2 = depth_reg - DEP_W'(2);
    assign stk_we      = cmd.run_start || cmd.push;
    assign stk_waddr   = cmd.push ? depth_reg[IDX_W-1:0] : '0;
    assign stk_wdata   = cmd.push ? next_idx : from_idx;
    assign stk_raddr   = depth_less2[IDX_W-1:0];

    // Next values of the datapath registers.
    always_comb begin
        edge_from_next = edge_from_reg;
        edge_to_next   = edge_to_reg;
        row_valid_next = row_valid_reg;
        rd_valid_next  = rd_valid_reg;
        visited_next   = visited_reg;
        depth_next     = depth_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_node_next  = out_node_reg;
        out_last_next  = out_last_reg;

        if (adj_re) begin
            rd_valid_next = row_valid_reg[adj_raddr];
        end
        if (cmd.add_read) begin
            edge_from_next = from_idx;
            edge_to_next   = to_idx;
        end
        if (cmd.add_write) begin
            row_valid_next[edge_from_reg] = 1'b1;
        end
        if (cmd.clear_graph) begin
            row_valid_next = '0;
        end
        if (cmd.run_start) begin
            visited_next = {{(NODES-1){1'b0}}, 1'b1} << from_idx;
            depth_next   = DEP_W'(1);
            pend_next    = from_idx;
        end
        // Descending releases the previous node with its last flag clear.
        if (cmd.push) begin
            visited_next   = visited_reg | ({{(NODES-1){1'b0}}, 1'b1} << next_idx);
            depth_next     = depth_reg + DEP_W'(1);
            pend_next      = next_idx;
            out_valid_next = 1'b1;
            out_node_next  = pend_reg;
            out_last_next  = 1'b0;
        end
        if (cmd.pop) begin
            depth_next = depth_reg - DEP_W'(1);
        end
        // The final node goes out with the last flag.
        if (cmd.finish) begin
            depth_next     = '0;
            out_valid_next = 1'b1;
            out_node_next  = pend_reg;
            out_last_next  = 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
            depth_reg     <= '0;
            out_valid_reg <= 1'b0;
            visited_reg   <= '0;
        end else begin
            row_valid_reg <= row_valid_next;
            depth_reg     <= depth_next;
            out_valid_reg <= out_valid_next;
            visited_reg   <= visited_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        edge_from_reg <= edge_from_next;
        edge_to_reg   <= edge_to_next;
        rd_valid_reg  <= rd_valid_next;
        pend_reg      <= pend_next;
        out_node_reg  <= out_node_next;
        out_last_reg  <= out_last_next;
    end

    dfsam_ram #(
        .WIDTH (NODES),
        .DEPTH (NODES)
    ) u_adj_ram (
        .aclk  (aclk),
        .we    (adj_we),
        .waddr (edge_from_reg),
        .wdata (adj_wdata),
        .re    (adj_re),
        .raddr (adj_raddr),
        .rdata (adj_rdata)
    );

    dfsam_ram #(
        .WIDTH (IDX_W),
        .DEPTH (NODES)
    ) u_stack_ram (
        .aclk  (aclk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (cmd.pop),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    // Output register.
    assign out_ext  = {{FW{1'b0}}, out_node_reg};
    assign m_tvalid = out_valid_reg;
    assign m_node   = out_ext[FW-1:0];
    assign m_tlast  = out_last_reg;

endmodule

### rtl/dfs_adjacency_matrix_walk.sv
// ============================================================================
// dfs_adjacency_matrix_walk: depth-first walk over an adjacency bit matrix
// Stores a directed graph as adjacency rows, adds edges, clears the graph
// and emits the nodes reached from a start node in depth-first order.
// ============================================================================
//
//  Channel  Direction  Beat contents
//  s_       in         tuser = opcode; tdata = from_node[3:0], to_node[7:4]
//  m_       out        tdata = visited_node[3:0], zeros above; tlast = last
//
//  An add reads the source row and writes it back. A run reads one row
//  per descent; a backtrack reads the parent off the node stack, then
//  its row, as each memory has a single read port. s_tready is high only
//  between items. A stalled m_ channel holds the walk when it next needs
//  to release a node. aresetn empties the graph at once.
//
module dfs_adjacency_matrix_walk #(
    parameter int NODES = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // tdata: from_node [3:0], to_node [7:4]
    input  logic [dfsam_pkg::S_TDATA_W-1:0] s_tdata,
    // tuser: opcode [1:0]
    input  logic [dfsam_pkg::OPCODE_W-1:0]  s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // tdata: visited_node [3:0], zeros [7:4]
    output logic [dfsam_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                            m_tlast
);

    localparam int FW = dfsam_pkg::NODE_FIELD_W;

    dfsam_pkg::cmd_t  cmd;
    dfsam_pkg::stat_t stat;
    logic [FW-1:0]    m_node;

    dfsam_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .opcode   (s_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    dfsam_dpath #(
        .NODES (NODES)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .from_node (s_tdata[FW-1:0]),
        .to_node   (s_tdata[2*FW-1:FW]),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_node    (m_node),
        .m_tlast   (m_tlast)
    );

    // Result beat: node index in the low bits.
    assign m_tdata = {{(dfsam_pkg::M_TDATA_W-FW){1'b0}}, m_node};

endmodule

### bench/dfs_adjacency_matrix_walk_test.sv
`timescale 1ns / 100ps
// ============================================================================
// dfs_adjacency_matrix_walk_test: self-checking bench for the depth-first walk
// Builds graphs with add-edge and clear beats, starts walks, and checks every
// visited node and its last flag against a predictor kept inside the bench.
// Both stream sides pause at random, except during one calm window.
// ============================================================================
module dfs_adjacency_matrix_walk_test;

    localparam int NODE_COUNT = 16;
    localparam int RANDOM_ITEMS = 150;
    localparam int CYCLE_LIMIT = 200000;
    // Margin after the last visit, scaled by the node count.
    localparam int DRAIN_CYCLES = 3 * NODE_COUNT + 8;
    localparam int CALM_FROM = 150;
    localparam int CALM_TO = 450;
    localparam int MAX_REPORTS = 10;
    localparam logic [dfsam_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;

    // One input beat, split into its fields.
    typedef struct {
        logic [dfsam_pkg::OPCODE_W-1:0]     op;
        logic [dfsam_pkg::NODE_FIELD_W-1:0] src;
        logic [dfsam_pkg::NODE_FIELD_W-1:0] dst;
    } graph_cmd_t;

    // One expected visit.
    typedef struct {
        logic [dfsam_pkg::NODE_FIELD_W-1:0] node;
        logic                               last;
    } visit_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [dfsam_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic [dfsam_pkg::OPCODE_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [dfsam_pkg::M_TDATA_W-1:0] m_tdata;
    logic m_tlast;

    graph_cmd_t pending_cmds[$];
    graph_cmd_t cmd_on_bus;
    bit cmd_in_flight = 1'b0;
    visit_t expected_visits[$];
    logic [NODE_COUNT-1:0] graph_rows [NODE_COUNT];

    int cycle_count = 0;
    int error_count = 0;
    int visits_checked = 0;
    int walks_run = 0;
    int edges_added = 0;
    int clears_done = 0;
    int ignored_beats = 0;
    int longest_walk = 0;

    dfs_adjacency_matrix_walk #(
        .NODES(NODE_COUNT)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Random pauses, switched off inside the calm window.
    function automatic bit take_break();
        if (cycle_count >= CALM_FROM && cycle_count < CALM_TO) begin
            return 1'b0;
        end
        return $urandom_range(0, 99) < 11;
    endfunction

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("ERROR @%0d: %s", cycle_count, msg);
        end
    endtask

    // Walk the graph depth-first from a start node, lowest successor first,
    // and queue each visited node with the last flag on the final one.
    function automatic void walk_from(input logic [dfsam_pkg::NODE_FIELD_W-1:0] start);
        logic [NODE_COUNT-1:0] seen;
        logic [NODE_COUNT-1:0] open;
        logic [dfsam_pkg::NODE_FIELD_W-1:0] trail [NODE_COUNT];
        int depth;
        int next;
        int walk_len;
        visit_t v;
        seen = '0;
        walk_len = 0;
        if (int'(start) >= NODE_COUNT) begin
            return;
        end
        seen[start] = 1'b1;
        v.node = start;
        v.last = 1'b0;
        expected_visits.insert(expected_visits.size(), v);
        walk_len++;
        trail[0] = start;
        depth = 1;
        while (depth > 0) begin
            open = graph_rows[trail[depth-1]] & ~seen;
            if (open == '0) begin
                depth--;
            end else begin
                next = 0;
                while (!open[next]) begin
                    next++;
                end
                seen[next] = 1'b1;
                v.node = next[dfsam_pkg::NODE_FIELD_W-1:0];
                expected_visits.insert(expected_visits.size(), v);
                walk_len++;
                trail[depth] = next[dfsam_pkg::NODE_FIELD_W-1:0];
                depth++;
            end
        end
        expected_visits[expected_visits.size()-1].last = 1'b1;
        if (walk_len > longest_walk) begin
            longest_walk = walk_len;
        end
    endfunction

    // Apply one accepted beat to the predicted graph.
    function automatic void apply_cmd(input graph_cmd_t c);
        case (c.op)
            dfsam_pkg::OP_ADD_EDGE: begin
                graph_rows[c.src][c.dst] = 1'b1;
                edges_added++;
            end
            dfsam_pkg::OP_RUN: begin
                walk_from(c.src);
                walks_run++;
            end
            dfsam_pkg::OP_CLEAR: begin
                foreach (graph_rows[i]) begin
                    graph_rows[i] = '0;
                end
                clears_done++;
            end
            default: begin
                ignored_beats++;
            end
        endcase
    endfunction

    function automatic void queue_cmd(input logic [dfsam_pkg::OPCODE_W-1:0] op,
                                      input int src, input int dst);
        graph_cmd_t c;
        c.op = op;
        c.src = src[dfsam_pkg::NODE_FIELD_W-1:0];
        c.dst = dst[dfsam_pkg::NODE_FIELD_W-1:0];
        pending_cmds.insert(pending_cmds.size(), c);
    endfunction

    // Sample both channels at the rising edge.
    always @(posedge aclk) begin
        visit_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d visits outstanding",
                     cycle_count, expected_visits.size());
            $display("Regression FAIL");
            $finish;
        end
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                apply_cmd(cmd_on_bus);
                cmd_in_flight = 1'b0;
            end
            if (m_tvalid && m_tready) begin
                if (expected_visits.size() == 0) begin
                    report_error($sformatf("unexpected beat node=%0d last=%0b",
                                           m_tdata[dfsam_pkg::NODE_FIELD_W-1:0],
                                           m_tlast));
                end else begin
                    want = expected_visits.pop_front();
                    visits_checked++;
                    if (m_tdata[dfsam_pkg::NODE_FIELD_W-1:0] !== want.node) begin
                        report_error($sformatf("visited_node expected %0d got %0d",
                                               want.node,
                                               m_tdata[dfsam_pkg::NODE_FIELD_W-1:0]));
                    end
                    if (m_tlast !== want.last) begin
                        report_error($sformatf("last expected %0b got %0b (node %0d)",
                                               want.last, m_tlast, want.node));
                    end
                    if (m_tdata[dfsam_pkg::M_TDATA_W-1:dfsam_pkg::NODE_FIELD_W] !== '0) begin
                        report_error($sformatf("tdata padding expected 0 got %0h",
                            m_tdata[dfsam_pkg::M_TDATA_W-1:dfsam_pkg::NODE_FIELD_W]));
                    end
                end
            end
        end
    end

    // Drive both channels at the falling edge.
    always @(negedge aclk) begin
        graph_cmd_t c;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end else begin
            if (!cmd_in_flight) begin
                if (pending_cmds.size() > 0 && !take_break()) begin
                    c = pending_cmds.pop_front();
                    cmd_on_bus = c;
                    cmd_in_flight = 1'b1;
                    s_tuser <= c.op;
                    s_tdata <= {c.dst, c.src};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= !take_break();
        end
    end

    // Fill the stimulus queue, then wait for the last visit to drain.
    initial begin
        int perm [NODE_COUNT];
        int useful;
        int pick;
        int len;
        int tmp;
        int j;

        foreach (graph_rows[i]) begin
            graph_rows[i] = '0;
        end

        // Directed part: unused opcode, empty walk, self loop, repeated
        // edge, lowest-successor order, backtracking and a clear.
        queue_cmd(OP_UNUSED, 0, 0);
        queue_cmd(dfsam_pkg::OP_RUN, 0, 0);
        queue_cmd(dfsam_pkg::OP_RUN, 15, 15);
        queue_cmd(dfsam_pkg::OP_ADD_EDGE, 0, 15);
        queue_cmd(dfsam_pkg::OP_ADD_EDGE, 15, 15);
        queue_cmd(dfsam_pkg::OP_ADD_EDGE, 0, 15);
        queue_cmd(dfsam_pkg::OP_ADD_EDGE, 15, 0);
        queue_cmd(dfsam_pkg::OP_ADD_EDGE, 0, 2);
        queue_cmd(dfsam_pkg::OP_ADD_EDGE, 0, 1);
        queue_cmd(dfsam_pkg::OP_ADD_EDGE, 1, 3);
        queue_cmd(dfsam_pkg::OP_RUN, 0, 0);
        queue_cmd(dfsam_pkg::OP_ADD_EDGE, 3, 0);
        queue_cmd(dfsam_pkg::OP_RUN, 15, 0);
        queue_cmd(dfsam_pkg::OP_RUN, 3, 15);
        queue_cmd(OP_UNUSED, 15, 15);
        queue_cmd(dfsam_pkg::OP_RUN, 15, 0);
        queue_cmd(dfsam_pkg::OP_CLEAR, 15, 15);
        queue_cmd(dfsam_pkg::OP_RUN, 15, 0);
        queue_cmd(dfsam_pkg::OP_RUN, 0, 0);

        // Random part: mostly graph builds followed by walks, some noise.
        useful = 0;
        while (useful < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                // A path through a shuffled node order, walked from its head.
                foreach (perm[i]) begin
                    perm[i] = i;
                end
                for (int i = NODE_COUNT - 1; i > 0; i--) begin
                    j = $urandom_range(0, i);
                    tmp = perm[i];
                    perm[i] = perm[j];
                    perm[j] = tmp;
                end
                queue_cmd(dfsam_pkg::OP_CLEAR, $urandom_range(0, 15),
                          $urandom_range(0, 15));
                len = ($urandom_range(0, 3) == 0) ? NODE_COUNT : $urandom_range(2, 15);
                for (int i = 0; i + 1 < len; i++) begin
                    queue_cmd(dfsam_pkg::OP_ADD_EDGE, perm[i], perm[i+1]);
                end
                if ($urandom_range(0, 1) == 1) begin
                    queue_cmd(dfsam_pkg::OP_ADD_EDGE, perm[len-1], perm[0]);
                    useful++;
                end
                queue_cmd(dfsam_pkg::OP_RUN, perm[0], $urandom_range(0, 15));
                useful += len + 1;
            end else if (pick < 65) begin
                // Random edges on top of the current graph, then walks.
                if ($urandom_range(0, 1) == 1) begin
                    queue_cmd(dfsam_pkg::OP_CLEAR, $urandom_range(0, 15),
                              $urandom_range(0, 15));
                    useful++;
                end
                len = $urandom_range(1, 12);
                for (int i = 0; i < len; i++) begin
                    queue_cmd(dfsam_pkg::OP_ADD_EDGE, $urandom_range(0, 15),
                              $urandom_range(0, 15));
                end
                for (int i = 0; i < $urandom_range(1, 3); i++) begin
                    queue_cmd(dfsam_pkg::OP_RUN, $urandom_range(0, 15),
                              $urandom_range(0, 15));
                    useful++;
                end
                useful += len;
            end else if (pick < 80) begin
                queue_cmd(dfsam_pkg::OP_RUN, $urandom_range(0, 15), $urandom_range(0, 15));
                useful++;
            end else begin
                // Noise: any opcode with any fields.
                tmp = $urandom_range(0, 3);
                queue_cmd(tmp[dfsam_pkg::OPCODE_W-1:0], $urandom_range(0, 15),
                          $urandom_range(0, 15));
                if (tmp != OP_UNUSED) begin
                    useful++;
                end
            end
        end

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (pending_cmds.size() > 0 || cmd_in_flight || expected_visits.size() > 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (expected_visits.size() > 0) begin
            report_error($sformatf("%0d expected visits never arrived",
                                   expected_visits.size()));
        end
        $display("Covered %0d walks (longest %0d nodes), %0d edge adds, %0d clears,",
                 walks_run, longest_walk, edges_added, clears_done);
        $display("%0d ignored beats and %0d checked visits in %0d cycles; %0d errors.",
                 ignored_beats, visits_checked, cycle_count, error_count);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
